@@ src/assert_macros.svh @@
// Assertion macros shared by the rasterizer RTL.
// Define NO_ASSERTIONS to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed")
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed")
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/blr_pkg.sv @@
// Shared types and constants of the Bresenham line rasterizer.
// Used by blr_walk and line_bresenham_raster; depends on nothing.
package blr_pkg;

	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 24;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int INC_S_BITS = COORD_BITS + 1;
	localparam int INC_D_BITS = COORD_BITS + 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_STEP  = 1'b1
	} mode_t;

	// One request as captured in the input register.
	typedef struct packed {
		mode_t  mode;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		color_t color;
	} req_t;

	// Walk state of the current line (everything except the active flag).
	typedef struct packed {
		coord_t                 major_pos;
		coord_t                 minor_pos;
		coord_t                 major_end;
		logic [ERR_BITS-1:0]    err;
		logic [INC_S_BITS-1:0]  inc_s;
		logic [INC_D_BITS-1:0]  inc_d;
		logic                   major_neg;
		logic                   minor_neg;
		logic                   swapped;
		color_t                 color;
	} walk_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_t;

	function automatic coord_t step_coord(coord_t v, logic neg);
		return neg ? v - coord_t'(1) : v + coord_t'(1);
	endfunction

endpackage

@@ src/blr_walk.sv @@
// Combinational line setup and single-pixel step of the rasterizer.
// Depends on blr_pkg.
module blr_walk import blr_pkg::*; (
	input  req_t   req,
	input  logic   active,
	input  walk_t  cur,
	output walk_t  nxt,
	output logic   nxt_active,
	output logic   emit,
	output pixel_t pix
);

	always_comb begin
		coord_t dx;
		coord_t dy;
		coord_t a1;
		coord_t b1;
		coord_t a2;
		coord_t b2;
		coord_t dmaj;
		coord_t dmin;
		coord_t next_pos;
		logic   swp;
		logic   last;

		dx = (req.ex >= req.sx) ? req.ex - req.sx : req.sx - req.ex;
		dy = (req.ey >= req.sy) ? req.ey - req.sy : req.sy - req.ey;
		swp = dx < dy;
		a1   = swp ? req.sy : req.sx;
		b1   = swp ? req.sx : req.sy;
		a2   = swp ? req.ey : req.ex;
		b2   = swp ? req.ex : req.ey;
		dmaj = swp ? dy : dx;
		dmin = swp ? dx : dy;
		next_pos = step_coord(cur.major_pos, cur.major_neg);
		last = next_pos == cur.major_end;

		nxt        = cur;
		nxt_active = active;
		emit       = 1'b0;
		pix        = '{x: cur.major_pos, y: cur.minor_pos, color: cur.color, last: last};

		unique case (req.mode)
			MODE_START: begin
				nxt.swapped   = swp;
				nxt.major_neg = !(a2 > a1);
				nxt.minor_neg = !(b2 > b1);
				nxt.major_end = a2;
				nxt.minor_pos = b1;
				nxt.major_pos = step_coord(a1, !(a2 > a1));
				nxt.inc_s     = {dmin, 1'b0};
				nxt.inc_d     = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
				nxt.err       = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
				nxt.color     = req.color;
				nxt_active    = dmaj > coord_t'(1);
				emit          = 1'b1;
				pix.x         = swp ? b1 : a1;
				pix.y         = swp ? a1 : b1;
				pix.color     = req.color;
				pix.last      = !(dmaj > coord_t'(1));
			end
			MODE_STEP: begin
				// Idle: drop the request, leave the state alone.
				if (active) begin
					if (cur.err[ERR_BITS-1]) begin
						nxt.err = cur.err + {2'b00, cur.inc_s};
					end else begin
						nxt.minor_pos = step_coord(cur.minor_pos, cur.minor_neg);
						nxt.err = cur.err + {cur.inc_d[INC_D_BITS-1], cur.inc_d};
					end
					nxt.major_pos = next_pos;
					emit          = 1'b1;
					pix.x         = cur.swapped ? nxt.minor_pos : cur.major_pos;
					pix.y         = cur.swapped ? cur.major_pos : nxt.minor_pos;
					if (last) begin
						nxt_active = 1'b0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule

@@ src/line_bresenham_raster.sv @@
// Bresenham line rasterizer, one pixel per request.
//
// Input channel (in_valid / in_stall): mode 0 starts a line from start_x/y
// toward end_x/y in pen_color and emits the first endpoint; mode 1 advances
// one pixel along the major axis and emits it. The far endpoint is not drawn.
// A step request with no line in progress emits nothing. A start request
// abandons any line in progress.
// Output channel (out_valid / out_stall): pixel_x, pixel_y, pixel_color and
// last_pixel, which marks the final pixel of the line.
// A request is captured in the input register, walked by one pass of
// add/compare logic, and its pixel is then held in the output register.
// While out_stall is low, one request per cycle is accepted and at most one
// pixel per cycle delivered; the error update is done in that one pass.
// When out_stall is high with a pixel waiting, the output register holds and
// in_stall rises once the input register also holds a request.
// Reset (arst_n low) empties both registers and ends any line in progress.
// Depends on blr_pkg, blr_walk and assert_macros.svh.
`include "assert_macros.svh"

module line_bresenham_raster import blr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0] pen_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	logic   valid_s1;
	req_t   req_s1;
	logic   active_q;
	walk_t  walk_q;
	logic   out_valid_q;
	pixel_t pix_q;

	walk_t  walk_nxt;
	logic   active_nxt;
	logic   emit;
	pixel_t pix;
	logic   out_ready;
	logic   s1_adv;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_adv    = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	blr_walk u_walk (
		.req        (req_s1),
		.active     (active_q),
		.cur        (walk_q),
		.nxt        (walk_nxt),
		.nxt_active (active_nxt),
		.emit       (emit),
		.pix        (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_adv) begin
				active_q <= active_nxt;
			end
			if (out_ready) begin
				out_valid_q <= s1_adv && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= '{mode: mode_t'(mode), sx: start_x, sy: start_y,
				ex: end_x, ey: end_y, color: pen_color};
		end
		if (s1_adv) begin
			walk_q <= walk_nxt;
		end
		// Hold the pixel while the receiver stalls.
		if (s1_adv && emit) begin
			pix_q <= pix;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pix_q.x;
	assign pixel_y     = pix_q.y;
	assign pixel_color = pix_q.color;
	assign last_pixel  = pix_q.last;

	`ASSERT_CLK(a_stall_needs_req, in_stall |-> valid_s1);
	`ASSERT_NEXT(a_emit_reaches_out, s1_adv && emit, out_valid_q);
	`ASSERT_NEXT(a_idle_step_silent, s1_adv && req_s1.mode == MODE_STEP && !active_q,
		!out_valid_q);
	`ASSERT_NEXT(a_last_ends_line, s1_adv && emit && pix.last, !active_q);

endmodule

@@ test/line_bresenham_raster_tb.sv @@
// Self-checking testbench for line_bresenham_raster: a scoreboard class predicts each pixel
// from the accepted requests and checks the pixel stream field by field.
// Depends on blr_pkg and the line_bresenham_raster RTL.
`timescale 1ns / 1ps

module line_bresenham_raster_tb;
	import blr_pkg::*;

	localparam int PIXEL_TARGET = 1300;
	localparam int CALM_TAIL    = 150;

	// Predicts the pixel stream of the rasterizer and checks the pixels that come out.
	class raster_tracker;
		pixel_t pending_pixels[$];
		int mismatches;
		int lines_started;
		int pixels_expected;
		int pixels_seen;
		int steps_ignored;

		logic                          active;
		coord_t                        major_pos;
		coord_t                        minor_pos;
		coord_t                        major_end;
		logic signed [ERR_BITS-1:0]    err;
		logic [INC_S_BITS-1:0]         inc_s;
		logic signed [INC_D_BITS-1:0]  inc_d;
		logic                          major_neg;
		logic                          minor_neg;
		logic                          swapped;
		color_t                        color;

		function new();
			active    = 1'b0;
			major_pos = '0;
			minor_pos = '0;
			major_end = '0;
			err       = '0;
			inc_s     = '0;
			inc_d     = '0;
			major_neg = 1'b0;
			minor_neg = 1'b0;
			swapped   = 1'b0;
			color     = '0;
		endfunction

		function coord_t step_along(coord_t v, logic neg);
			return neg ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
		endfunction

		function void queue_pixel(coord_t maj, coord_t mnr, logic is_last);
			pixel_t p;
			p.x     = swapped ? mnr : maj;
			p.y     = swapped ? maj : mnr;
			p.color = color;
			p.last  = is_last;
			pending_pixels.push_back(p);
			pixels_expected++;
		endfunction

		function void take_request(mode_t m, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
				color_t col);
			int dx, dy, dmaj, dmin;
			coord_t a1, b1, a2, b2, nxt;
			logic is_last;
			if (m == MODE_START) begin
				dx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
				dy = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
				swapped = dx < dy;
				if (swapped) begin
					a1 = sy; b1 = sx; a2 = ey; b2 = ex; dmaj = dy; dmin = dx;
				end else begin
					a1 = sx; b1 = sy; a2 = ex; b2 = ey; dmaj = dx; dmin = dy;
				end
				color     = col;
				major_neg = !(a2 > a1);
				minor_neg = !(b2 > b1);
				major_end = a2;
				minor_pos = b1;
				major_pos = step_along(a1, major_neg);
				inc_s     = INC_S_BITS'(2 * dmin);
				inc_d     = INC_D_BITS'(2 * (dmin - dmaj));
				err       = ERR_BITS'(2 * dmin - dmaj);
				active    = dmaj > 1;
				lines_started++;
				queue_pixel(a1, b1, !active);
				return;
			end
			if (!active) begin
				steps_ignored++;
				return;
			end
			// negative error keeps the minor coordinate, otherwise take a diagonal step
			if (err[ERR_BITS-1]) begin
				err = err + inc_s;
			end else begin
				minor_pos = step_along(minor_pos, minor_neg);
				err = err + inc_d;
			end
			nxt = step_along(major_pos, major_neg);
			is_last = nxt == major_end;
			queue_pixel(major_pos, minor_pos, is_last);
			major_pos = nxt;
			if (is_last)
				active = 1'b0;
		endfunction

		function void check_pixel(coord_t x, coord_t y, color_t c, logic is_last);
			pixel_t want;
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
						x, y, c, is_last);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (x !== want.x || y !== want.y || c !== want.color || is_last !== want.last) begin
				if (mismatches < 10)
					$display("pixel %0d: expected %0d,%0d %06h %0b got %0d,%0d %06h %0b",
						pixels_seen, want.x, want.y, want.color, want.last,
						x, y, c, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	logic   mode;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	color_t pen_color;
	logic   out_valid;
	logic   out_stall;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last_pixel;

	raster_tracker tracker = new();
	bit calm = 1'b0;
	int input_stall_cycles = 0;

	line_bresenham_raster uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pen_color   (pen_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("line_bresenham_raster_tb: errors");
		$finish;
	end

	// Drive one request and hold it until the block takes it.
	task automatic send_request(mode_t m, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			color_t col);
		in_valid  <= 1'b1;
		mode      <= m;
		start_x   <= sx;
		start_y   <= sy;
		end_x     <= ex;
		end_y     <= ey;
		pen_color <= col;
		do @(posedge clk); while (in_stall);
		tracker.take_request(m, sx, sy, ex, ey, col);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Fields are ignored on a step request; randomize them anyway.
	task automatic send_step();
		send_request(MODE_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), color_t'($urandom));
	endtask

	task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, color_t col,
			int steps);
		send_request(MODE_START, sx, sy, ex, ey, col);
		repeat (steps) send_step();
	endtask

	function automatic int major_span(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		int dx, dy;
		dx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
		dy = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
		return (dx > dy) ? dx : dy;
	endfunction

	// Offset a coordinate by up to +-reach, folding back when it leaves the range.
	function automatic coord_t near_coord(coord_t base, int reach);
		int delta, v;
		delta = $urandom_range(0, 2 * reach) - reach;
		v = int'(base) + delta;
		if (v < 0 || v > 4095)
			v = int'(base) - delta;
		return coord_t'(v);
	endfunction

	// Pixel sink: random stall bursts, one long hold-off to back up the pipeline.
	initial begin
		int burst_left;
		int hold_left;
		bit held;
		burst_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel);
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (!held && tracker.pixels_seen >= 60) begin
				held = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(1, 8) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		coord_t sx, sy, ex, ey;
		color_t col;
		int span, full, steps, reach, pick;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		mode      <= MODE_START;
		start_x   <= '0;
		start_y   <= '0;
		end_x     <= '0;
		end_y     <= '0;
		pen_color <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle step, degenerate and unit lines, extremes, octants, flat minor axis
		send_step();
		draw_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 24'hFFFFFF, 0);
		draw_line(12'd0, 12'd0, 12'd1, 12'd0, 24'h000000, 0);
		draw_line(12'd10, 12'd10, 12'd10, 12'd11, 24'h123456, 0);
		draw_line(12'd0, 12'd0, 12'd4095, 12'd4095, 24'hA5A5A5, 2);
		draw_line(12'd4095, 12'd0, 12'd0, 12'd4095, 24'h5A5A5A, 1);
		for (int oct = 0; oct < 8; oct++) begin
			ex = oct[0] ? 12'd2003 : 12'd1997;
			ey = oct[1] ? 12'd2001 : 12'd1999;
			if (oct[2])
				draw_line(12'd2000, 12'd2000, ey, ex, color_t'($urandom), 2);
			else
				draw_line(12'd2000, 12'd2000, ex, ey, color_t'($urandom), 2);
		end
		draw_line(12'd50, 12'd60, 12'd47, 12'd60, 24'h00FF00, 3);

		// random: mostly complete short lines, some abandoned long ones, some stray steps
		while (tracker.pixels_expected < PIXEL_TARGET) begin
			if (tracker.pixels_expected >= PIXEL_TARGET - CALM_TAIL)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			col = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0)
				: color_t'($urandom);
			if (pick < 8) begin
				send_step();
			end else if (pick < 16) begin
				sx = coord_t'($urandom);
				sy = coord_t'($urandom);
				ex = coord_t'($urandom);
				ey = coord_t'($urandom);
				span = major_span(sx, sy, ex, ey);
				full = (span > 1) ? span - 1 : 0;
				steps = $urandom_range(0, 20);
				draw_line(sx, sy, ex, ey, col, (steps < full) ? steps : full);
			end else begin
				case ($urandom_range(0, 4))
					0: reach = 1;
					1: reach = 2;
					2: reach = 5;
					3: reach = 16;
					default: reach = 40;
				endcase
				sx = coord_t'($urandom);
				sy = coord_t'($urandom);
				ex = near_coord(sx, reach);
				ey = near_coord(sy, reach);
				span = major_span(sx, sy, ex, ey);
				full = (span > 1) ? span - 1 : 0;
				pick = $urandom_range(0, 99);
				if (pick < 80)
					steps = full;
				else if (pick < 90)
					steps = $urandom_range(0, full);
				else
					steps = full + $urandom_range(1, 3);
				draw_line(sx, sy, ex, ey, col, steps);
			end
		end
		in_valid <= 1'b0;

		while (tracker.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Drew %0d lines, checked %0d pixels; %0d steps arrived with no line active.",
			tracker.lines_started, tracker.pixels_seen, tracker.steps_ignored);
		$display("Input side was held off for %0d cycles; %0d pixel mismatches.",
			input_stall_cycles, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
			$display("line_bresenham_raster_tb: clean");
		end else begin
			$display("line_bresenham_raster_tb: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/blr_pkg.sv
src/blr_walk.sv
src/line_bresenham_raster.sv
test/line_bresenham_raster_tb.sv
